>>> rtl/bgs_pkg.sv
// Shared constants, codes and types of the bar graph scaler.
package bgs_pkg;

    localparam int MAX_SAMPLES = 63;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int SAMPLE_W    = 32;
    localparam int COORD_W     = 12;
    localparam int POS_W       = 13;
    localparam int COLOR_W     = 8;
    localparam int KIND_W      = 2;
    localparam int ES_W        = 2;
    localparam int REG_IDX_W   = 3;
    localparam int REG_DATA_W  = 12;

    typedef logic [KIND_W-1:0]    t_kind;
    typedef logic [ES_W-1:0]      t_esize;
    typedef logic [REG_IDX_W-1:0] t_reg_idx;

    // Command kinds.
    localparam t_kind KIND_BG     = 2'd0;
    localparam t_kind KIND_FLAT   = 2'd1;
    localparam t_kind KIND_RELIEF = 2'd2;

    // Element size codes.
    localparam t_esize ES_BYTE = 2'd0;
    localparam t_esize ES_HALF = 2'd1;
    localparam t_esize ES_WORD = 2'd2;
    localparam t_esize ES_NONE = 2'd3;

    // Configuration register indexes.
    localparam t_reg_idx REG_ORIGIN_X     = 3'd0;
    localparam t_reg_idx REG_ORIGIN_Y     = 3'd1;
    localparam t_reg_idx REG_AREA_WIDTH   = 3'd2;
    localparam t_reg_idx REG_AREA_HEIGHT  = 3'd3;
    localparam t_reg_idx REG_FG_COLOR     = 3'd4;
    localparam t_reg_idx REG_BG_COLOR     = 3'd5;
    localparam t_reg_idx REG_ELEMENT_SIZE = 3'd6;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [COORD_W-1:0] rect_width;
        logic [COORD_W-1:0] rect_height;
        logic [COLOR_W-1:0] color;
        logic               last_command;
    } t_cmd;

endpackage

>>> rtl/bgs_cfg_if.sv
// Configuration write channel of the bar graph scaler.
interface bgs_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [bgs_pkg::REG_IDX_W-1:0]     index;
    logic [bgs_pkg::REG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/bgs_in_if.sv
// Sample input channel of the bar graph scaler.
interface bgs_in_if;
    logic                            valid;
    logic                            ready;
    logic [bgs_pkg::SAMPLE_W-1:0]    sample;
    logic                            last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink (input valid, input sample, input last_sample, output ready);
endinterface

>>> rtl/bgs_out_if.sv
// Draw command output channel of the bar graph scaler.
interface bgs_out_if;
    logic                           valid;
    logic                           ready;
    logic [bgs_pkg::KIND_W-1:0]     kind;
    logic [bgs_pkg::POS_W-1:0]      pos_x;
    logic [bgs_pkg::POS_W-1:0]      pos_y;
    logic [bgs_pkg::COORD_W-1:0]    rect_width;
    logic [bgs_pkg::COORD_W-1:0]    rect_height;
    logic [bgs_pkg::COLOR_W-1:0]    color;
    logic                           last_command;

    modport source (output valid, output kind, output pos_x, output pos_y,
                    output rect_width, output rect_height, output color,
                    output last_command, input ready);
    modport sink (input valid, input kind, input pos_x, input pos_y,
                  input rect_width, input rect_height, input color,
                  input last_command, output ready);
endinterface

>>> rtl/bar_graph_scaler_top.sv
// Bar graph scaler: collects samples and emits background and bar draw commands.
// A sample that is not the last one is taken and leaves the input ready for the next sample.
// After the last sample the sequencer runs a check, 12 divide steps (skipped when the count is
// clamped), a scan of the samples, a span step, read, value and emit steps per bar, and finish.
// Output stalls hold emit and finish; input is not ready until the final command is registered.
// Synchronous active-low reset clears configuration and control; the sample RAM is not cleared.
module bar_graph_scaler_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bgs_cfg_if.sink     i_cfg,
    bgs_in_if.sink      i_in,
    bgs_out_if.source   o_out
);

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_DIV    = 4'd2;
    localparam logic [3:0] S_SCAN   = 4'd3;
    localparam logic [3:0] S_SPAN   = 4'd4;
    localparam logic [3:0] S_BRD    = 4'd5;
    localparam logic [3:0] S_BV     = 4'd6;
    localparam logic [3:0] S_BEMIT  = 4'd7;
    localparam logic [3:0] S_FINISH = 4'd8;

    localparam int STEP_W = $clog2(bgs_pkg::COORD_W);
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(bgs_pkg::COORD_W - 1);

    // Configuration registers. The write port never stalls.
    logic [bgs_pkg::COORD_W-1:0] r_origin_x, r_origin_y, r_area_w, r_area_h;
    logic [bgs_pkg::COLOR_W-1:0] r_fg_color, r_bg_color;
    bgs_pkg::t_esize             r_esize;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_area_w   <= '0;
            r_area_h   <= '0;
            r_fg_color <= '0;
            r_bg_color <= '0;
            r_esize    <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                bgs_pkg::REG_ORIGIN_X:     r_origin_x <= i_cfg.data;
                bgs_pkg::REG_ORIGIN_Y:     r_origin_y <= i_cfg.data;
                bgs_pkg::REG_AREA_WIDTH:   r_area_w   <= i_cfg.data;
                bgs_pkg::REG_AREA_HEIGHT:  r_area_h   <= i_cfg.data;
                bgs_pkg::REG_FG_COLOR:     r_fg_color <= i_cfg.data[bgs_pkg::COLOR_W-1:0];
                bgs_pkg::REG_BG_COLOR:     r_bg_color <= i_cfg.data[bgs_pkg::COLOR_W-1:0];
                bgs_pkg::REG_ELEMENT_SIZE: r_esize    <= i_cfg.data[bgs_pkg::ES_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer and datapath registers.
    logic [3:0]                   r_state, n_state;
    logic [bgs_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic [bgs_pkg::SAMPLE_W-1:0] r_min, n_min, r_max, n_max;
    logic [bgs_pkg::CNT_W-1:0]    r_n, n_n;
    logic [bgs_pkg::COORD_W-1:0]  r_itw, n_itw;
    logic [bgs_pkg::COORD_W-1:0]  r_dq, n_dq;
    logic [bgs_pkg::CNT_W-1:0]    r_rem, n_rem;
    logic [STEP_W-1:0]            r_step, n_step;
    logic [bgs_pkg::CNT_W-1:0]    r_idx, n_idx;
    logic                         r_sv, n_sv;
    logic [bgs_pkg::COORD_W-1:0]  r_span, n_span, r_extra, n_extra, r_v, n_v;
    logic [bgs_pkg::POS_W-1:0]    r_x, n_x;
    logic                         r_pv, n_pv, r_ov, n_ov;
    bgs_pkg::t_cmd                r_pend, n_pend, r_out, n_out;

    // Sample store.
    logic                         ram_we;
    logic [bgs_pkg::SAMPLE_W-1:0] ram_wdata, ram_rdata;

    bgs_ram #(
        .WIDTH (bgs_pkg::SAMPLE_W),
        .DEPTH (bgs_pkg::MAX_SAMPLES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt[bgs_pkg::ADDR_W-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx[bgs_pkg::ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign i_in.ready = (r_state == S_IDLE);

    assign o_out.valid        = r_ov;
    assign o_out.kind         = r_out.kind;
    assign o_out.pos_x        = r_out.pos_x;
    assign o_out.pos_y        = r_out.pos_y;
    assign o_out.rect_width   = r_out.rect_width;
    assign o_out.rect_height  = r_out.rect_height;
    assign o_out.color        = r_out.color;
    assign o_out.last_command = r_out.last_command;

    always_comb begin
        logic                         push_ok;
        logic                         out_free;
        logic [bgs_pkg::CNT_W:0]      div_t;
        logic [bgs_pkg::CNT_W:0]      div_d;
        logic                         div_ge;
        logic [bgs_pkg::SAMPLE_W-1:0] diff;
        bgs_pkg::t_cmd                bar;

        n_state  = r_state;
        n_cnt    = r_cnt;
        n_min    = r_min;
        n_max    = r_max;
        n_n      = r_n;
        n_itw    = r_itw;
        n_dq     = r_dq;
        n_rem    = r_rem;
        n_step   = r_step;
        n_idx    = r_idx;
        n_sv     = r_sv;
        n_span   = r_span;
        n_extra  = r_extra;
        n_v      = r_v;
        n_x      = r_x;
        n_pv     = r_pv;
        n_pend   = r_pend;
        n_ov     = r_ov;
        n_out    = r_out;
        ram_we   = 1'b0;
        ram_wdata = i_in.sample;

        // The output register empties when its word is taken.
        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end
        out_free = !r_ov || o_out.ready;
        // A new command can enter the pending slot when that slot is empty or can move on.
        push_ok  = !r_pv || out_free;

        div_t  = {r_rem, r_dq[bgs_pkg::COORD_W-1]};
        div_d  = {1'b0, r_n};
        div_ge = (div_t >= div_d);
        diff   = ram_rdata - r_min;

        bar.kind         = (r_itw < bgs_pkg::COORD_W'(2)) ? bgs_pkg::KIND_FLAT
                                                          : bgs_pkg::KIND_RELIEF;
        bar.pos_x        = r_x;
        bar.pos_y        = bgs_pkg::POS_W'(r_origin_y) + bgs_pkg::POS_W'(r_span - r_v);
        bar.rect_width   = r_itw;
        bar.rect_height  = r_v + r_extra;
        bar.color        = r_fg_color;
        bar.last_command = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    unique case (r_esize)
                        bgs_pkg::ES_BYTE: ram_wdata = {24'd0, i_in.sample[7:0]};
                        bgs_pkg::ES_HALF: ram_wdata = {16'd0, i_in.sample[15:0]};
                        default:          ram_wdata = i_in.sample;
                    endcase
                    // Samples past the store's depth are dropped.
                    if (r_cnt < bgs_pkg::CNT_W'(bgs_pkg::MAX_SAMPLES)) begin
                        ram_we = 1'b1;
                        n_cnt  = r_cnt + 1'b1;
                    end
                    if (i_in.last_sample) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (r_area_w == '0 || r_area_h == '0) begin
                    n_cnt   = '0;
                    n_min   = '1;
                    n_max   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_pend.kind         = bgs_pkg::KIND_BG;
                    n_pend.pos_x        = bgs_pkg::POS_W'(r_origin_x);
                    n_pend.pos_y        = bgs_pkg::POS_W'(r_origin_y);
                    n_pend.rect_width   = r_area_w;
                    n_pend.rect_height  = r_area_h;
                    n_pend.color        = r_bg_color;
                    n_pend.last_command = 1'b0;
                    n_pv                = 1'b1;
                    n_idx               = '0;
                    n_sv                = 1'b0;
                    if (r_esize == bgs_pkg::ES_NONE) begin
                        n_state = S_FINISH;
                    end else if (bgs_pkg::COORD_W'(r_cnt) > r_area_w) begin
                        n_n     = r_area_w[bgs_pkg::CNT_W-1:0];
                        n_itw   = bgs_pkg::COORD_W'(1);
                        n_state = S_SCAN;
                    end else begin
                        n_n     = r_cnt;
                        n_dq    = r_area_w;
                        n_rem   = '0;
                        n_step  = '0;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                // One restoring division step of area width by the count.
                n_rem  = div_ge ? bgs_pkg::CNT_W'(div_t - div_d) : div_t[bgs_pkg::CNT_W-1:0];
                n_dq   = {r_dq[bgs_pkg::COORD_W-2:0], div_ge};
                n_step = r_step + 1'b1;
                if (r_step == DIV_LAST) begin
                    n_itw   = {r_dq[bgs_pkg::COORD_W-2:0], div_ge};
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // Reads run one ahead of the compare; r_sv marks valid read data.
                if (r_sv) begin
                    if (ram_rdata > r_max) n_max = ram_rdata;
                    if (ram_rdata < r_min) n_min = ram_rdata;
                end
                if (r_idx != r_n) begin
                    n_idx = r_idx + 1'b1;
                    n_sv  = 1'b1;
                end else begin
                    n_sv = 1'b0;
                    if (!r_sv) begin
                        n_state = S_SPAN;
                    end
                end
            end
            S_SPAN: begin
                diff = r_max - r_min;
                n_x   = bgs_pkg::POS_W'(r_origin_x);
                n_idx = '0;
                if (diff == '0) begin
                    n_state = S_FINISH;
                end else begin
                    if (diff > bgs_pkg::SAMPLE_W'(r_area_h)) begin
                        n_span  = r_area_h;
                        n_extra = '0;
                    end else begin
                        n_span  = diff[bgs_pkg::COORD_W-1:0];
                        n_extra = r_area_h - diff[bgs_pkg::COORD_W-1:0];
                    end
                    n_state = S_BRD;
                end
            end
            S_BRD: begin
                n_state = S_BV;
            end
            S_BV: begin
                n_v = (diff > bgs_pkg::SAMPLE_W'(r_span)) ? r_span
                                                          : diff[bgs_pkg::COORD_W-1:0];
                n_state = S_BEMIT;
            end
            S_BEMIT: begin
                // A bar at the minimum draws nothing but still takes its column.
                if (r_v == '0 || push_ok) begin
                    if (r_v != '0) begin
                        if (r_pv) begin
                            n_out = r_pend;
                            n_out.last_command = 1'b0;
                            n_ov = 1'b1;
                        end
                        n_pend = bar;
                        n_pv   = 1'b1;
                    end
                    n_x = r_x + bgs_pkg::POS_W'(r_itw);
                    if (r_idx == r_n - 1'b1) begin
                        n_state = S_FINISH;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_BRD;
                    end
                end
            end
            S_FINISH: begin
                // The held command is the graph's final word.
                if (out_free) begin
                    if (r_pv) begin
                        n_out = r_pend;
                        n_out.last_command = 1'b1;
                        n_ov = 1'b1;
                    end
                    n_pv    = 1'b0;
                    n_cnt   = '0;
                    n_min   = '1;
                    n_max   = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_min   <= '1;
            r_max   <= '0;
            r_sv    <= 1'b0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_min   <= n_min;
            r_max   <= n_max;
            r_sv    <= n_sv;
            r_pv    <= n_pv;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_itw   <= n_itw;
        r_dq    <= n_dq;
        r_rem   <= n_rem;
        r_step  <= n_step;
        r_idx   <= n_idx;
        r_span  <= n_span;
        r_extra <= n_extra;
        r_v     <= n_v;
        r_x     <= n_x;
        r_pend  <= n_pend;
        r_out   <= n_out;
    end

endmodule

>>> rtl/bgs_ram.sv
// Generic simple dual port RAM with registered read data.
module bgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
